// File: sv/vfr_pkg.sv
// ----------------------------------------------------------------------------
// vfr_pkg: shared types and constants for the vector frame redirect block
// Fixed-point widths, thresholds, status codes and vector types used by the
// datapath, the unit-vector pipeline and the port checker.
// ----------------------------------------------------------------------------
package vfr_pkg;
	localparam int COMP_BITS = 20;
	localparam int VEC_BITS = 3 * COMP_BITS;
	localparam int WB = 34;
	localparam int UB = 32;
	localparam int OB = 18;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = UB - 1;
	localparam int UNIT_LAT = SQRT_STEPS + DIV_STEPS + 6;

	localparam logic [63:0] MIN_SQ_Q32 = 64'd43;
	localparam logic [63:0] MIN_SQ_Q60 = 64'd11529215047;
	localparam logic signed [OB-1:0] OUT_MAX = 18'sd65536;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_INPUT,
		ST_BAD_AXIS,
		ST_BAD_RESULT
	} status_t;

	typedef logic signed [WB-1:0] wcomp_t;
	typedef wcomp_t [2:0] wvec_t;
	typedef logic signed [UB-1:0] ucomp_t;
	typedef ucomp_t [2:0] uvec_t;
	typedef logic signed [63:0] prod_t;

	function automatic wvec_t unpack_vec(input logic [VEC_BITS-1:0] word);
		wvec_t v;
		for (int i = 0; i < 3; i++) begin
			v[i] = WB'($signed(word[i*COMP_BITS +: COMP_BITS]));
		end
		return v;
	endfunction

	function automatic wcomp_t widen(input ucomp_t a);
		return WB'(a);
	endfunction

	function automatic prod_t mul(input wcomp_t a, input wcomp_t b);
		return prod_t'(a) * prod_t'(b);
	endfunction
endpackage

// File: sv/vfr_unit.sv
// ----------------------------------------------------------------------------
// vfr_unit: pipelined vector normalizer
// Squared-length check, leading-bit scaling, 32-step integer square root and
// 31-step rounded division per component, one stage per step.
// ----------------------------------------------------------------------------
module vfr_unit (
	input  logic clk,
	input  logic en,
	input  vfr_pkg::wvec_t vec,
	input  logic [63:0] min_sq,
	output vfr_pkg::uvec_t unit,
	output logic ok
);
	import vfr_pkg::*;

	localparam int RB = WB + 1;
	localparam int NL = DIV_STEPS;

	logic signed [2*WB-1:0] sqv [3];
	logic [63:0] sq_s1 [3];
	logic [WB-1:0] mag_s1 [3];
	wvec_t vec_s1;

	logic [63:0] sum_c;
	logic [WB-1:0] or_c;
	logic [4:0] sh_c;
	wvec_t vec_s2;
	logic [4:0] sh_s2;
	logic ok_s2;

	wvec_t w_s3;
	logic ok_s3;
	logic signed [2*WB-1:0] sqw [3];

	logic [63:0] rn_s [SQRT_STEPS+1];
	logic [63:0] rr_s [SQRT_STEPS+1];
	wvec_t rw_s [SQRT_STEPS+1];
	logic rok_s [SQRT_STEPS+1];
	logic [63:0] sbit [SQRT_STEPS];
	logic [63:0] trial [SQRT_STEPS];

	logic [WB-1:0] root;
	logic [WB-1:0] wmag [3];
	logic [63:0] num [3];

	logic [RB-1:0] dr_s [DIV_STEPS+1][3];
	logic [NL-1:0] dq_s [DIV_STEPS+1][3];
	logic [NL-1:0] dn_s [DIV_STEPS+1][3];
	logic [2:0] dneg_s [DIV_STEPS+1];
	logic [WB-1:0] dd_s [DIV_STEPS+1];
	logic dok_s [DIV_STEPS+1];
	logic [RB-1:0] dt [DIV_STEPS][3];
	ucomp_t qv [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sqv[i] = vec[i] * vec[i];
			sqw[i] = w_s3[i] * w_s3[i];
		end
		sum_c = sq_s1[0] + sq_s1[1] + sq_s1[2];
		or_c = mag_s1[0] | mag_s1[1] | mag_s1[2];
		sh_c = '0;
		for (int b = 0; b < 30; b++) begin
			if (or_c[b]) begin
				sh_c = 5'(30 - b);
			end
		end
		if (|or_c[WB-1:30]) begin
			sh_c = '0;
		end
		for (int j = 0; j < SQRT_STEPS; j++) begin
			sbit[j] = 64'd1 << (2*SQRT_STEPS - 2 - 2*j);
			trial[j] = rr_s[j] + sbit[j];
		end
		root = rr_s[SQRT_STEPS][WB-1:0];
		for (int i = 0; i < 3; i++) begin
			wmag[i] = rw_s[SQRT_STEPS][i][WB-1] ? -rw_s[SQRT_STEPS][i] : rw_s[SQRT_STEPS][i];
			num[i] = (64'(wmag[i]) << 30) + 64'(root >> 1);
			qv[i] = UB'(dq_s[DIV_STEPS][i]);
		end
		for (int j = 0; j < DIV_STEPS; j++) begin
			for (int i = 0; i < 3; i++) begin
				dt[j][i] = {dr_s[j][i][RB-2:0], dn_s[j][i][NL-1]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= vec;
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= sqv[i][63:0];
				mag_s1[i] <= vec[i][WB-1] ? -vec[i] : vec[i];
			end

			vec_s2 <= vec_s1;
			sh_s2 <= sh_c;
			ok_s2 <= sum_c >= min_sq;

			for (int i = 0; i < 3; i++) begin
				w_s3[i] <= vec_s2[i] <<< sh_s2;
			end
			ok_s3 <= ok_s2;

			rn_s[0] <= sqw[0][63:0] + sqw[1][63:0] + sqw[2][63:0];
			rr_s[0] <= '0;
			rw_s[0] <= w_s3;
			rok_s[0] <= ok_s3;

			for (int j = 0; j < SQRT_STEPS; j++) begin
				if (rn_s[j] >= trial[j]) begin
					rn_s[j+1] <= rn_s[j] - trial[j];
					rr_s[j+1] <= (rr_s[j] >> 1) + sbit[j];
				end else begin
					rn_s[j+1] <= rn_s[j];
					rr_s[j+1] <= rr_s[j] >> 1;
				end
				rw_s[j+1] <= rw_s[j];
				rok_s[j+1] <= rok_s[j];
			end

			for (int i = 0; i < 3; i++) begin
				dr_s[0][i] <= RB'(num[i] >> NL);
				dn_s[0][i] <= num[i][NL-1:0];
				dq_s[0][i] <= '0;
				dneg_s[0][i] <= rw_s[SQRT_STEPS][i][WB-1];
			end
			dd_s[0] <= root;
			dok_s[0] <= rok_s[SQRT_STEPS];

			for (int j = 0; j < DIV_STEPS; j++) begin
				for (int i = 0; i < 3; i++) begin
					if (dt[j][i] >= {1'b0, dd_s[j]}) begin
						dr_s[j+1][i] <= dt[j][i] - {1'b0, dd_s[j]};
						dq_s[j+1][i] <= {dq_s[j][i][NL-2:0], 1'b1};
					end else begin
						dr_s[j+1][i] <= dt[j][i];
						dq_s[j+1][i] <= {dq_s[j][i][NL-2:0], 1'b0};
					end
					dn_s[j+1][i] <= {dn_s[j][i][NL-2:0], 1'b0};
				end
				dneg_s[j+1] <= dneg_s[j];
				dd_s[j+1] <= dd_s[j];
				dok_s[j+1] <= dok_s[j];
			end

			for (int i = 0; i < 3; i++) begin
				unit[i] <= dneg_s[DIV_STEPS][i] ? -qv[i] : qv[i];
			end
			ok <= dok_s[DIV_STEPS];
		end
	end
endmodule

// File: sv/vector_frame_redirect.sv
// ----------------------------------------------------------------------------
// vector_frame_redirect: direction re-expressed from one frame in another
// Normalizes inputs, builds both orthonormal frames, projects and rebuilds the
// direction, and returns a Q1.16 unit vector with a status code.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the result is not stalled; four normalizer
// pipelines in series set the depth.
// A stalled result holds the whole pipeline; the input register still takes one word.
// Reset clears all valid bits at once; datapath registers are not reset.
module vector_frame_redirect (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  logic [vfr_pkg::VEC_BITS-1:0] dir_vec,
	input  logic [vfr_pkg::VEC_BITS-1:0] src_forward,
	input  logic [vfr_pkg::VEC_BITS-1:0] src_up_hint,
	input  logic [vfr_pkg::VEC_BITS-1:0] dst_forward,
	input  logic [vfr_pkg::VEC_BITS-1:0] dst_up_hint,
	output logic result_valid,
	input  logic result_ready,
	output logic signed [vfr_pkg::OB-1:0] out_x,
	output logic signed [vfr_pkg::OB-1:0] out_y,
	output logic signed [vfr_pkg::OB-1:0] out_z,
	output logic [1:0] status
);
	import vfr_pkg::*;

	localparam int IX_DIR = 0;
	localparam int IX_SF = 1;
	localparam int IX_SH = 2;
	localparam int IX_DF = 3;
	localparam int IX_DH = 4;
	localparam int VL = 4*UNIT_LAT + 8;
	localparam int FA_LEN = 2*UNIT_LAT + 6;
	localparam int FB_LEN = 2*UNIT_LAT + 4;
	localparam int RB_LEN = UNIT_LAT + 4;
	localparam int OKB_LEN = UNIT_LAT + 2;
	localparam int CODE_LEN = UNIT_LAT + 4;

	typedef prod_t prod6_t [6];

	function automatic prod6_t cross_prod(input uvec_t a, input uvec_t b);
		prod6_t p;
		p[0] = mul(widen(a[1]), widen(b[2]));
		p[1] = mul(widen(a[2]), widen(b[1]));
		p[2] = mul(widen(a[2]), widen(b[0]));
		p[3] = mul(widen(a[0]), widen(b[2]));
		p[4] = mul(widen(a[0]), widen(b[1]));
		p[5] = mul(widen(a[1]), widen(b[0]));
		return p;
	endfunction

	logic en;
	logic [VEC_BITS-1:0] in_w [5];
	wvec_t in_s1 [5];
	logic v_s1;
	logic vld_s [1:VL];

	uvec_t ua [5];
	logic ua_ok [5];
	uvec_t ub [2];
	logic ub_ok [2];
	uvec_t uc [2];
	logic uc_ok [2];
	uvec_t uf;
	logic uf_ok;

	prod6_t xa_p_s1 [2];
	wvec_t xa_v_s2 [2];
	prod6_t xb_p_s1 [2];
	wvec_t xb_v_s2 [2];

	uvec_t fa_dir_s [1:FA_LEN];
	uvec_t fa_sf_s [1:FA_LEN];
	uvec_t fa_df_s [1:FA_LEN];
	logic fb_bad_s [1:FB_LEN];
	uvec_t rb_sr_s [1:RB_LEN];
	uvec_t rb_dr_s [1:RB_LEN];
	logic okb_s [1:OKB_LEN];
	status_t code_s [1:CODE_LEN];
	uvec_t du_s [1:2];

	prod_t dp_s1 [3][3];
	wcomp_t lc_s2 [3];
	prod_t ep_s1 [3][3];
	wvec_t res_s2;

	status_t code_c;
	status_t st_c;
	logic signed [UB-1:0] rnd [3];
	logic signed [OB-1:0] clp [3];

	logic result_valid_q;
	logic signed [OB-1:0] out_q [3];
	status_t status_q;

	assign en = !result_valid_q || result_ready;
	assign item_ready = en || !v_s1;
	assign in_w[IX_DIR] = dir_vec;
	assign in_w[IX_SF] = src_forward;
	assign in_w[IX_SH] = src_up_hint;
	assign in_w[IX_DF] = dst_forward;
	assign in_w[IX_DH] = dst_up_hint;

	for (genvar g = 0; g < 5; g++) begin : g_in
		vfr_unit u_unit (
			.clk(clk), .en(en), .vec(in_s1[g]), .min_sq(MIN_SQ_Q32),
			.unit(ua[g]), .ok(ua_ok[g])
		);
	end

	for (genvar f = 0; f < 2; f++) begin : g_frame
		vfr_unit u_right (
			.clk(clk), .en(en), .vec(xa_v_s2[f]), .min_sq(MIN_SQ_Q60),
			.unit(ub[f]), .ok(ub_ok[f])
		);
		vfr_unit u_up (
			.clk(clk), .en(en), .vec(xb_v_s2[f]), .min_sq(MIN_SQ_Q60),
			.unit(uc[f]), .ok(uc_ok[f])
		);
	end

	vfr_unit u_result (
		.clk(clk), .en(en), .vec(res_s2), .min_sq(MIN_SQ_Q60),
		.unit(uf), .ok(uf_ok)
	);

	always_comb begin
		if (fb_bad_s[FB_LEN]) begin
			code_c = ST_BAD_INPUT;
		end else if (!okb_s[OKB_LEN] || !uc_ok[0] || !uc_ok[1]) begin
			code_c = ST_BAD_AXIS;
		end else begin
			code_c = ST_OK;
		end
		if (code_s[CODE_LEN] != ST_OK) begin
			st_c = code_s[CODE_LEN];
		end else if (!uf_ok) begin
			st_c = ST_BAD_RESULT;
		end else begin
			st_c = ST_OK;
		end
		for (int i = 0; i < 3; i++) begin
			rnd[i] = (uf[i] + UB'(8192)) >>> 14;
			if (rnd[i] > UB'(OUT_MAX)) begin
				clp[i] = OUT_MAX;
			end else if (rnd[i] < -UB'(OUT_MAX)) begin
				clp[i] = -OUT_MAX;
			end else begin
				clp[i] = OB'(rnd[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 1; k <= VL; k++) begin
				vld_s[k] <= 1'b0;
			end
			result_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				v_s1 <= item_valid;
			end
			if (en) begin
				vld_s[1] <= v_s1;
				for (int k = 2; k <= VL; k++) begin
					vld_s[k] <= vld_s[k-1];
				end
				result_valid_q <= vld_s[VL];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			for (int g = 0; g < 5; g++) begin
				in_s1[g] <= unpack_vec(in_w[g]);
			end
		end
		if (en) begin
			// frame right axes: forward x up hint
			xa_p_s1[0] <= cross_prod(ua[IX_SF], ua[IX_SH]);
			xa_p_s1[1] <= cross_prod(ua[IX_DF], ua[IX_DH]);
			// true up: right x forward
			xb_p_s1[0] <= cross_prod(ub[0], fa_sf_s[OKB_LEN]);
			xb_p_s1[1] <= cross_prod(ub[1], fa_df_s[OKB_LEN]);
			for (int f = 0; f < 2; f++) begin
				for (int i = 0; i < 3; i++) begin
					xa_v_s2[f][i] <= WB'((xa_p_s1[f][2*i] - xa_p_s1[f][2*i+1]) >>> 30);
					xb_v_s2[f][i] <= WB'((xb_p_s1[f][2*i] - xb_p_s1[f][2*i+1]) >>> 30);
				end
			end

			fa_dir_s[1] <= ua[IX_DIR];
			fa_sf_s[1] <= ua[IX_SF];
			fa_df_s[1] <= ua[IX_DF];
			for (int k = 2; k <= FA_LEN; k++) begin
				fa_dir_s[k] <= fa_dir_s[k-1];
				fa_sf_s[k] <= fa_sf_s[k-1];
				fa_df_s[k] <= fa_df_s[k-1];
			end
			fb_bad_s[1] <= !(ua_ok[0] && ua_ok[1] && ua_ok[2] && ua_ok[3] && ua_ok[4]);
			for (int k = 2; k <= FB_LEN; k++) begin
				fb_bad_s[k] <= fb_bad_s[k-1];
			end
			rb_sr_s[1] <= ub[0];
			rb_dr_s[1] <= ub[1];
			for (int k = 2; k <= RB_LEN; k++) begin
				rb_sr_s[k] <= rb_sr_s[k-1];
				rb_dr_s[k] <= rb_dr_s[k-1];
			end
			okb_s[1] <= ub_ok[0] && ub_ok[1];
			for (int k = 2; k <= OKB_LEN; k++) begin
				okb_s[k] <= okb_s[k-1];
			end
			code_s[1] <= code_c;
			for (int k = 2; k <= CODE_LEN; k++) begin
				code_s[k] <= code_s[k-1];
			end
			du_s[1] <= uc[1];
			du_s[2] <= du_s[1];

			// local coordinates in the source frame
			for (int i = 0; i < 3; i++) begin
				dp_s1[0][i] <= mul(widen(fa_dir_s[FB_LEN][i]), widen(rb_sr_s[OKB_LEN][i]));
				dp_s1[1][i] <= mul(widen(fa_dir_s[FB_LEN][i]), widen(uc[0][i]));
				dp_s1[2][i] <= mul(widen(fa_dir_s[FB_LEN][i]), widen(fa_sf_s[FB_LEN][i]));
			end
			for (int a = 0; a < 3; a++) begin
				lc_s2[a] <= WB'((dp_s1[a][0] + dp_s1[a][1] + dp_s1[a][2]) >>> 30);
			end

			// rebuild in the destination frame
			for (int i = 0; i < 3; i++) begin
				ep_s1[i][0] <= mul(widen(rb_dr_s[RB_LEN][i]), lc_s2[0]);
				ep_s1[i][1] <= mul(widen(du_s[2][i]), lc_s2[1]);
				ep_s1[i][2] <= mul(widen(fa_df_s[FA_LEN][i]), lc_s2[2]);
			end
			for (int i = 0; i < 3; i++) begin
				res_s2[i] <= WB'((ep_s1[i][0] + ep_s1[i][1] + ep_s1[i][2]) >>> 30);
			end

			for (int i = 0; i < 3; i++) begin
				out_q[i] <= (st_c == ST_OK) ? clp[i] : '0;
			end
			status_q <= st_c;
		end
	end

	assign result_valid = result_valid_q;
	assign out_x = out_q[0];
	assign out_y = out_q[1];
	assign out_z = out_q[2];
	assign status = status_q;
endmodule

// File: sv/vfr_checker.sv
// ----------------------------------------------------------------------------
// vfr_checker: port-level checks for vector_frame_redirect
// Result word hold, status-versus-value consistency, output range and input accept when empty.
// ----------------------------------------------------------------------------
module vfr_checker (
	input logic clk,
	input logic arst_n,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input logic signed [vfr_pkg::OB-1:0] out_x,
	input logic signed [vfr_pkg::OB-1:0] out_y,
	input logic signed [vfr_pkg::OB-1:0] out_z,
	input logic [1:0] status
);
	import vfr_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(out_x)
		&& $stable(out_y) && $stable(out_z) && $stable(status))
		else $error("result word changed while stalled");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |-> out_x == 0 && out_y == 0 && out_z == 0)
		else $error("nonzero vector with failure status");

	a_nonzero_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_OK |-> out_x != 0 || out_y != 0 || out_z != 0)
		else $error("zero vector with ok status");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> out_x <= OUT_MAX && out_x >= -OUT_MAX && out_y <= OUT_MAX
		&& out_y >= -OUT_MAX && out_z <= OUT_MAX && out_z >= -OUT_MAX)
		else $error("component out of unit range");

	a_free_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input stalled with empty output");
endmodule

bind vector_frame_redirect vfr_checker u_vfr_checker (.*);

// File: tb/vector_frame_redirect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_frame_redirect_tb: self-checking bench for the frame redirect block
// Drives directed rows (degenerate inputs and axes, component extremes, simple
// frames), then random frame pairs under four idle/stall mixes. Each result
// word is matched to its fixed row value or an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module vector_frame_redirect_tb;
	import vfr_pkg::*;

	typedef logic [VEC_BITS-1:0] pvec_t;
	typedef longint v3_t [3];

	typedef struct {
		pvec_t dir, sf, su, df, du;
		bit fixed;
		logic signed [OB-1:0] ex, ey, ez;
		status_t est;
	} frame_row_t;

	typedef struct {
		logic signed [OB-1:0] x, y, z;
		status_t st;
	} redirect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	pvec_t dir_vec = '0, src_forward = '0, src_up_hint = '0, dst_forward = '0,
		dst_up_hint = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [OB-1:0] out_x, out_y, out_z;
	logic [1:0] status;

	// bench-side copy of the typed expectation, held with the payload
	bit row_fixed = 1'b0;
	redirect_t row_exp;

	redirect_t pending_redirects[$];
	frame_row_t rows[$];
	int n_accepted = 0;
	int n_results = 0;
	int n_errors = 0;
	int n_bad[4] = '{0, 0, 0, 0};
	int sender_idle = 0;
	int rx_stall = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	vector_frame_redirect DUT (.*);

	always #10 clk = ~clk;

	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic pvec_t mk(input int x, input int y, input int z);
		logic [COMP_BITS-1:0] a, b, c;
		a = x[COMP_BITS-1:0];
		b = y[COMP_BITS-1:0];
		c = z[COMP_BITS-1:0];
		return {c, b, a};
	endfunction

	function automatic longint unsigned len_sq(input v3_t v);
		return longint'(v[0] * v[0]) + longint'(v[1] * v[1]) + longint'(v[2] * v[2]);
	endfunction

	function automatic longint unsigned root64(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit to_unit(input v3_t v, input longint unsigned lim, output v3_t u);
		v3_t w;
		longint m, a, n;
		longint unsigned s, mag, q;
		u = '{0, 0, 0};
		if (len_sq(v) < lim) return 0;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			w[i] = v[i];
			a = w[i] < 0 ? -w[i] : w[i];
			if (a > m) m = a;
		end
		while (m < 64'sd1073741824) begin
			for (int i = 0; i < 3; i++) w[i] = w[i] * 2;
			m = m * 2;
		end
		s = root64(len_sq(w));
		for (int i = 0; i < 3; i++) begin
			n = w[i] * 64'sd1073741824;
			mag = n < 0 ? -n : n;
			q = (mag + s / 2) / s;
			u[i] = n < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic void cross_q30(input v3_t a, input v3_t b, output v3_t r);
		r[0] = (a[1] * b[2] - a[2] * b[1]) >>> 30;
		r[1] = (a[2] * b[0] - a[0] * b[2]) >>> 30;
		r[2] = (a[0] * b[1] - a[1] * b[0]) >>> 30;
	endfunction

	function automatic bit axes_of(input v3_t f, input v3_t h, output v3_t r, output v3_t up);
		v3_t t;
		up = '{0, 0, 0};
		cross_q30(f, h, t);
		if (!to_unit(t, MIN_SQ_Q60, r)) return 0;
		cross_q30(r, f, t);
		return to_unit(t, MIN_SQ_Q60, up);
	endfunction

	function automatic redirect_t redirect_of(input pvec_t w[5]);
		v3_t raw[5], un[5];
		v3_t sr, su, dr, du, res, fin;
		longint lr, lu, lf, o;
		logic [COMP_BITS-1:0] c;
		redirect_t r;
		r = '{0, 0, 0, ST_OK};
		for (int k = 0; k < 5; k++) begin
			for (int i = 0; i < 3; i++) begin
				c = w[k][i*COMP_BITS +: COMP_BITS];
				raw[k][i] = longint'($signed(c));
			end
			if (!to_unit(raw[k], MIN_SQ_Q32, un[k])) r.st = ST_BAD_INPUT;
		end
		if (r.st != ST_OK) return r;
		if (!axes_of(un[1], un[2], sr, su) | !axes_of(un[3], un[4], dr, du)) begin
			r.st = ST_BAD_AXIS;
			return r;
		end
		lr = (un[0][0] * sr[0] + un[0][1] * sr[1] + un[0][2] * sr[2]) >>> 30;
		lu = (un[0][0] * su[0] + un[0][1] * su[1] + un[0][2] * su[2]) >>> 30;
		lf = (un[0][0] * un[1][0] + un[0][1] * un[1][1] + un[0][2] * un[1][2]) >>> 30;
		for (int i = 0; i < 3; i++)
			res[i] = (dr[i] * lr + du[i] * lu + un[3][i] * lf) >>> 30;
		if (!to_unit(res, MIN_SQ_Q60, fin)) begin
			r.st = ST_BAD_RESULT;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			o = (fin[i] + 8192) >>> 14;
			if (o > 65536) o = 65536;
			if (o < -65536) o = -65536;
			if (i == 0) r.x = o[OB-1:0];
			else if (i == 1) r.y = o[OB-1:0];
			else r.z = o[OB-1:0];
		end
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %0s at result %0d: got %0d expected %0d", what, n_results, got, want);
		n_errors++;
	endtask

	// input word monitor
	always @(posedge clk) begin
		pvec_t w[5];
		if (item_valid && item_ready) begin
			w = '{dir_vec, src_forward, src_up_hint, dst_forward, dst_up_hint};
			pending_redirects.push_back(row_fixed ? row_exp : redirect_of(w));
			n_accepted++;
		end
	end

	// result word monitor
	always @(posedge clk) begin
		redirect_t e;
		if (result_valid && result_ready) begin
			if (pending_redirects.size() == 0) begin
				report("unexpected word", int'(status), -1);
			end else begin
				e = pending_redirects.pop_front();
				if (out_x !== e.x) report("out_x", out_x, e.x);
				if (out_y !== e.y) report("out_y", out_y, e.y);
				if (out_z !== e.z) report("out_z", out_z, e.z);
				if (status !== e.st) report("status", status, e.st);
				n_bad[e.st]++;
			end
			n_results++;
		end
	end

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 700;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_stall);
		end
	end

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send(input frame_row_t r);
		int target;
		target = n_accepted + 1;
		while ($urandom_range(99) < sender_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		dir_vec <= r.dir;
		src_forward <= r.sf;
		src_up_hint <= r.su;
		dst_forward <= r.df;
		dst_up_hint <= r.du;
		row_fixed <= r.fixed;
		row_exp <= '{r.ex, r.ey, r.ez, r.est};
		item_valid <= 1'b1;
		do @(negedge clk); while (n_accepted != target);
	endtask

	function automatic int rcomp();
		case ($urandom_range(3))
			0: return int'($signed(COMP_BITS'($urandom)));
			1: return $signed($urandom_range(8191)) - 4096;
			2: return $signed($urandom_range(16)) - 8;
			default: return $signed($urandom_range(131071)) - 65536;
		endcase
	endfunction

	function automatic pvec_t rvec();
		return mk(rcomp(), rcomp(), rcomp());
	endfunction

	function automatic frame_row_t rand_row();
		frame_row_t r;
		int k;
		r = '{rvec(), rvec(), rvec(), rvec(), rvec(), 0, 0, 0, 0, ST_OK};
		k = $urandom_range(99);
		if (k < 3) begin
			case ($urandom_range(4))
				0: r.dir = '0;
				1: r.sf = '0;
				2: r.su = '0;
				3: r.df = '0;
				default: r.du = '0;
			endcase
		end else if (k < 6) begin
			r.su = r.sf;
		end else if (k < 9) begin
			r.du = r.df;
		end
		return r;
	endfunction

	localparam int ONE = 65536;
	localparam int PMAX = 524287;
	localparam int NMAX = -524288;

	initial begin
		int idle_mix[4][2];
		idle_mix = '{'{0, 0}, '{56, 0}, '{0, 56}, '{38, 38}};

		rows.push_back('{'0, mk(0, 0, ONE), mk(0, ONE, 0), mk(0, 0, ONE), mk(0, ONE, 0),
			1, 0, 0, 0, ST_BAD_INPUT});
		rows.push_back('{mk(1, 1, 1), mk(0, 0, ONE), mk(0, ONE, 0), mk(0, 0, ONE),
			mk(0, ONE, 0), 1, 0, 0, 0, ST_BAD_INPUT});
		rows.push_back('{mk(6, 0, 0), mk(0, 0, ONE), mk(0, ONE, 0), mk(0, 0, ONE),
			mk(0, ONE, 0), 1, 0, 0, 0, ST_BAD_INPUT});
		rows.push_back('{mk(ONE, 0, 0), mk(0, 0, ONE), mk(0, ONE, 0), mk(0, 0, ONE),
			'0, 1, 0, 0, 0, ST_BAD_INPUT});
		rows.push_back('{mk(ONE, 0, 0), mk(0, 0, ONE), mk(0, 0, 2 * ONE), mk(0, 0, ONE),
			mk(0, ONE, 0), 1, 0, 0, 0, ST_BAD_AXIS});
		rows.push_back('{mk(ONE, 0, 0), mk(0, 0, ONE), mk(0, ONE, 0), mk(NMAX, NMAX, NMAX),
			mk(PMAX, PMAX, PMAX), 1, 0, 0, 0, ST_BAD_AXIS});
		rows.push_back('{mk(7, 0, 0), mk(0, 0, ONE), mk(0, ONE, 0), mk(0, 0, ONE),
			mk(0, ONE, 0), 0, 0, 0, 0, ST_OK});
		rows.push_back('{mk(ONE, 0, 0), mk(0, 0, ONE), mk(0, ONE, 0), mk(0, 0, ONE),
			mk(0, ONE, 0), 0, 0, 0, 0, ST_OK});
		rows.push_back('{mk(0, ONE, 0), mk(0, 0, ONE), mk(0, ONE, 0), mk(ONE, 0, 0),
			mk(0, 0, ONE), 0, 0, 0, 0, ST_OK});
		rows.push_back('{mk(NMAX, PMAX, NMAX), mk(PMAX, NMAX, 1), mk(NMAX, 0, PMAX),
			mk(PMAX, PMAX, NMAX), mk(1, NMAX, PMAX), 0, 0, 0, 0, ST_OK});
		rows.push_back('{mk(PMAX, PMAX, PMAX), mk(NMAX, 0, 0), mk(0, NMAX, 0),
			mk(0, 0, PMAX), mk(PMAX, 0, 0), 0, 0, 0, 0, ST_OK});
		rows.push_back('{mk(-1, -1, -7), mk(0, 0, -ONE), mk(7, 7, 0), mk(-ONE, 0, 0),
			mk(0, -ONE, 0), 0, 0, 0, 0, ST_OK});
		rows.push_back('{mk(3, -5, 4), mk(ONE, ONE, 0), mk(0, 0, ONE), mk(0, ONE, ONE),
			mk(ONE, 0, 0), 0, 0, 0, 0, ST_OK});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) send(rows[i]);

		for (int p = 0; p < 4; p++) begin
			item_valid <= 1'b0;
			wait (pending_redirects.size() == 0);
			@(negedge clk);
			sender_idle = idle_mix[p][0];
			rx_stall = idle_mix[p][1];
			if (p == 0) hold_req = 1'b1;
			repeat (485) send(rand_row());
		end
		item_valid <= 1'b0;
		wait (pending_redirects.size() == 0);
		repeat (300) @(posedge clk);

		$display("sent %0d words through four idle/stall mixes with one long output hold",
			n_accepted);
		$display("results %0d: ok %0d, bad input %0d, bad axis %0d, bad result %0d",
			n_results, n_bad[0], n_bad[1], n_bad[2], n_bad[3]);
		if (n_errors == 0 && pending_redirects.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

// File: files.f
sv/vfr_pkg.sv
sv/vfr_unit.sv
sv/vector_frame_redirect.sv
sv/vfr_checker.sv
tb/vector_frame_redirect_tb.sv
